// ===== rtl/tmprof_pkg.sv =====
// Shared types, constants and control word layout for the trapezoid motion profile block.
package tmprof_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS      = 16;
    localparam int TICK_W         = 24;
    localparam int CREEP_W        = 31;
    localparam int TOL_W          = 31;
    localparam int CFG_INDEX_W    = 2;
    localparam int CFG_DATA_W     = 32;

    localparam logic [TICK_W-1:0]  TICK_RESET  = 24'd16777;
    localparam logic [CREEP_W-1:0] CREEP_RESET = 31'd327680;
    localparam logic [TOL_W-1:0]   TOL_RESET   = 31'd8192;

    typedef enum logic [1:0] {
        CMD_TICK,
        CMD_START,
        CMD_CLEAR,
        CMD_NONE
    } cmd_t;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_ACCEL,
        PH_BRAKE,
        PH_DONE
    } phase_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_TICK_SECONDS,
        REG_CREEP_SPEED,
        REG_FINISH_TOL
    } cfg_reg_t;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_REM,
        OP_SAVE_DV,
        OP_SAVE_SQ,
        OP_DIFF,
        OP_BRAKE,
        OP_SPEED,
        OP_POS,
        OP_CMD
    } op_t;

    typedef enum logic [1:0] {
        SRC_ACCEL,
        SRC_SPEED,
        SRC_END,
        SRC_REM
    } asrc_t;

    typedef enum logic [1:0] {
        SRCB_TICK,
        SRCB_SPEED,
        SRCB_END,
        SRCB_AMIN
    } bsrc_t;

    typedef enum logic [1:0] {
        PART_LL,
        PART_LH,
        PART_HL,
        PART_HH
    } part_t;

    typedef struct packed {
        op_t   op;
        logic  mul_en;
        logic  mul_clr;
        asrc_t a_src;
        bsrc_t b_src;
        part_t part;
    } ctrl_t;

    typedef struct packed {
        logic not_tick;
        logic idle_phase;
        logic not_accel;
    } status_t;

    localparam ctrl_t CTRL_NOP = '{
        op:      OP_NOP,
        mul_en:  1'b0,
        mul_clr: 1'b0,
        a_src:   SRC_ACCEL,
        b_src:   SRCB_TICK,
        part:    PART_LL
    };

endpackage

// ===== rtl/tmprof_mul.sv =====
// Shared half-width multiplier that accumulates four partial products into a full product.
module tmprof_mul #(
    parameter int DATA_WIDTH = tmprof_pkg::DATA_WIDTH_DEF
) (
    input  logic                      clk,
    input  logic                      en,
    input  logic                      clr,
    input  tmprof_pkg::part_t         part,
    input  logic [DATA_WIDTH-1:0]     a,
    input  logic [DATA_WIDTH-1:0]     b,
    output logic [2*DATA_WIDTH-1:0]   acc
);
    import tmprof_pkg::*;

    localparam int H    = (DATA_WIDTH + 1) / 2;
    localparam int PW   = 2 * DATA_WIDTH;
    localparam int SH_W = $clog2(PW + 1);
    localparam logic [SH_W-1:0] SH_ONE = SH_W'(H);
    localparam logic [SH_W-1:0] SH_TWO = SH_W'(2 * H);

    logic [H-1:0]    a_lo, a_hi, b_lo, b_hi;
    logic [H-1:0]    a_part, b_part;
    logic [SH_W-1:0] sh;
    logic [2*H-1:0]  pp;
    logic [PW-1:0]   shifted;
    logic [PW-1:0]   acc_reg, acc_next;

    always_comb
    begin
        a_lo = a[H-1:0];
        a_hi = H'(a >> H);
        b_lo = b[H-1:0];
        b_hi = H'(b >> H);
        case (part)
            PART_LL:
            begin
                a_part = a_lo;
                b_part = b_lo;
                sh     = '0;
            end
            PART_LH:
            begin
                a_part = a_lo;
                b_part = b_hi;
                sh     = SH_ONE;
            end
            PART_HL:
            begin
                a_part = a_hi;
                b_part = b_lo;
                sh     = SH_ONE;
            end
            default:
            begin
                a_part = a_hi;
                b_part = b_hi;
                sh     = SH_TWO;
            end
        endcase
        pp       = a_part * b_part;
        shifted  = PW'(pp) << sh;
        acc_next = (clr ? '0 : acc_reg) + shifted;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule

// ===== rtl/tmprof_datapath.sv =====
// Motion state, operand selection, update logic, configuration and result registers.
module tmprof_datapath #(
    parameter int DATA_WIDTH = tmprof_pkg::DATA_WIDTH_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  tmprof_pkg::ctrl_t                       ctrl,
    input  logic                                    accept,
    input  logic                                    emit,
    input  logic [1:0]                              command,
    input  logic signed [DATA_WIDTH-1:0]            move_distance,
    input  logic signed [DATA_WIDTH-1:0]            top_speed,
    input  logic signed [DATA_WIDTH-1:0]            final_speed,
    input  logic signed [DATA_WIDTH-1:0]            accel_rate,
    input  logic                                    cfg_write,
    input  logic [tmprof_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [tmprof_pkg::CFG_DATA_W-1:0]       cfg_data,
    output tmprof_pkg::status_t                     status,
    output logic [1:0]                              phase,
    output logic signed [DATA_WIDTH-1:0]            speed_now,
    output logic signed [DATA_WIDTH-1:0]            position_now,
    output logic                                    done_res
);
    import tmprof_pkg::*;

    localparam int W  = DATA_WIDTH;
    localparam int PW = 2 * W;
    localparam int CW = ((W > 32) ? W : 32) + 2;

    localparam logic signed [W-1:0]  VMAX       = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0]  VMIN       = {1'b1, {(W-1){1'b0}}};
    localparam logic signed [CW-1:0] VMAX_W     = $signed({{(CW-W+1){1'b0}}, {(W-1){1'b1}}});
    localparam logic signed [CW-1:0] VMIN_W     = ~VMAX_W;
    localparam logic [W-1:0]         FRAC_ONE_U = W'(1) << FRAC_BITS;

    function automatic logic [W-1:0] mag_of(input logic signed [W-1:0] x);
        mag_of = x[W-1] ? ((~x) + W'(1)) : x;
    endfunction

    function automatic logic [W-1:0] sat_mag(input logic signed [W-1:0] x);
        sat_mag = (x == VMIN) ? VMAX : mag_of(x);
    endfunction

    function automatic logic signed [W-1:0] apply_sign(input logic [W-1:0] m, input logic neg);
        apply_sign = neg ? ((~m) + W'(1)) : m;
    endfunction

    function automatic logic signed [W-1:0] sat_wide(input logic signed [CW-1:0] x);
        if (x > VMAX_W)
        begin
            sat_wide = VMAX;
        end
        else if (x < VMIN_W)
        begin
            sat_wide = VMIN;
        end
        else
        begin
            sat_wide = x[W-1:0];
        end
    endfunction

    // motion state
    phase_t               phase_reg, phase_next;
    logic                 reverse_reg, reverse_next;
    logic signed [W-1:0]  speed_reg, speed_next;
    logic signed [W-1:0]  position_reg, position_next;
    logic [W-1:0]         target_reg, target_next;
    logic signed [W-1:0]  limit_reg, limit_next;
    logic signed [W-1:0]  end_reg, end_next;
    logic [W-1:0]         accel_reg, accel_next;

    // scratch
    logic [W-1:0]         dv_reg, dv_next;
    logic signed [W:0]    rem_reg, rem_next;
    logic [PW-1:0]        sq_reg, sq_next;

    // captured item
    cmd_t                 cmd_reg;
    logic signed [W-1:0]  dist_reg, top_reg, fin_reg, acc_in_reg;

    // configuration
    logic [TICK_W-1:0]    tick_reg;
    logic [CREEP_W-1:0]   creep_reg;
    logic [TOL_W-1:0]     tol_reg;

    // result
    phase_t               res_phase_reg;
    logic signed [W-1:0]  res_speed_reg, res_position_reg;
    logic                 res_done_reg;

    logic [W-1:0]         mul_a, mul_b;
    logic [PW-1:0]        acc;

    logic [W-1:0]         speed_mag, end_mag, dist_mag, top_mag, fin_mag, acc_mag;
    logic signed [W-1:0]  fin_clamp;
    logic signed [CW-1:0] creep_w, creep_s, rem_w, tol_w;
    logic signed [W-1:0]  creep_lim;
    logic                 brake;
    logic signed [W:0]    sp_e, lim_e, dv_e, up_e, dn_e;
    logic [W-1:0]         tt_mag;
    logic signed [W:0]    tt_e, pos_e;
    logic signed [CW-1:0] pos_w;

    always_comb
    begin
        speed_mag = mag_of(speed_reg);
        end_mag   = mag_of(end_reg);

        case (ctrl.a_src)
            SRC_ACCEL: mul_a = accel_reg;
            SRC_SPEED: mul_a = speed_mag;
            SRC_END:   mul_a = end_mag;
            default:   mul_a = rem_reg[W-1:0];
        endcase

        case (ctrl.b_src)
            SRCB_TICK:  mul_b = W'(tick_reg);
            SRCB_SPEED: mul_b = speed_mag;
            SRCB_END:   mul_b = end_mag;
            default:    mul_b = (accel_reg < FRAC_ONE_U) ? FRAC_ONE_U : accel_reg;
        endcase
    end

    tmprof_mul #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_mul (
        .clk  (clk),
        .en   (ctrl.mul_en),
        .clr  (ctrl.mul_clr),
        .part (ctrl.part),
        .a    (mul_a),
        .b    (mul_b),
        .acc  (acc)
    );

    always_comb
    begin
        dist_mag  = mag_of(dist_reg);
        fin_clamp = (fin_reg > top_reg) ? top_reg : fin_reg;
        top_mag   = sat_mag(top_reg);
        fin_mag   = sat_mag(fin_clamp);
        acc_mag   = sat_mag(acc_in_reg);

        creep_w   = CW'(creep_reg);
        creep_s   = reverse_reg ? -creep_w : creep_w;
        creep_lim = sat_wide(creep_s);
        brake     = rem_reg[W] || ({acc[PW-2:0], 1'b0} < sq_reg);

        sp_e  = {speed_reg[W-1], speed_reg};
        lim_e = {limit_reg[W-1], limit_reg};
        dv_e  = $signed({1'b0, dv_reg});
        up_e  = sp_e + dv_e;
        dn_e  = sp_e - dv_e;

        tt_mag = acc[TICK_W +: W];
        tt_e   = speed_reg[W-1] ? -$signed({1'b0, tt_mag}) : $signed({1'b0, tt_mag});
        pos_e  = {position_reg[W-1], position_reg} + tt_e;
        pos_w  = CW'(pos_e);

        rem_w = CW'(rem_reg);
        tol_w = CW'(tol_reg);
    end

    always_comb
    begin
        phase_next    = phase_reg;
        reverse_next  = reverse_reg;
        speed_next    = speed_reg;
        position_next = position_reg;
        target_next   = target_reg;
        limit_next    = limit_reg;
        end_next      = end_reg;
        accel_next    = accel_reg;
        dv_next       = dv_reg;
        rem_next      = rem_reg;
        sq_next       = sq_reg;

        case (ctrl.op)
            OP_REM:
            begin
                rem_next = $signed({1'b0, target_reg}) - $signed({1'b0, mag_of(position_reg)});
            end
            OP_SAVE_DV:
            begin
                dv_next = acc[TICK_W +: W];
            end
            OP_SAVE_SQ:
            begin
                sq_next = acc;
            end
            OP_DIFF:
            begin
                sq_next = (sq_reg >= acc) ? (sq_reg - acc) : (acc - sq_reg);
            end
            OP_BRAKE:
            begin
                if (brake)
                begin
                    phase_next = PH_BRAKE;
                    limit_next = (end_reg == '0) ? creep_lim : end_reg;
                end
            end
            OP_SPEED:
            begin
                if (speed_reg < limit_reg)
                begin
                    speed_next = (up_e > lim_e) ? limit_reg : up_e[W-1:0];
                end
                else if (speed_reg > limit_reg)
                begin
                    speed_next = (dn_e < lim_e) ? limit_reg : dn_e[W-1:0];
                end
            end
            OP_POS:
            begin
                position_next = sat_wide(pos_w);
                if (rem_w < tol_w)
                begin
                    phase_next = PH_DONE;
                    limit_next = end_reg;
                end
            end
            OP_CMD:
            begin
                case (cmd_reg)
                    CMD_START:
                    begin
                        reverse_next = dist_reg[W-1];
                        if (dist_mag < FRAC_ONE_U)
                        begin
                            phase_next = PH_DONE;
                        end
                        else
                        begin
                            target_next   = dist_mag;
                            position_next = '0;
                            limit_next    = apply_sign(top_mag, dist_reg[W-1]);
                            end_next      = apply_sign(fin_mag, dist_reg[W-1]);
                            accel_next    = acc_mag;
                            phase_next    = PH_ACCEL;
                        end
                    end
                    CMD_CLEAR:
                    begin
                        phase_next    = PH_IDLE;
                        reverse_next  = 1'b0;
                        speed_next    = '0;
                        position_next = '0;
                        target_next   = '0;
                        limit_next    = '0;
                        end_next      = '0;
                        accel_next    = '0;
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            reverse_reg  <= 1'b0;
            speed_reg    <= '0;
            position_reg <= '0;
            target_reg   <= '0;
            limit_reg    <= '0;
            end_reg      <= '0;
            accel_reg    <= '0;
            tick_reg     <= TICK_RESET;
            creep_reg    <= CREEP_RESET;
            tol_reg      <= TOL_RESET;
        end
        else
        begin
            phase_reg    <= phase_next;
            reverse_reg  <= reverse_next;
            speed_reg    <= speed_next;
            position_reg <= position_next;
            target_reg   <= target_next;
            limit_reg    <= limit_next;
            end_reg      <= end_next;
            accel_reg    <= accel_next;
            if (cfg_write)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_TICK_SECONDS: tick_reg  <= cfg_data[TICK_W-1:0];
                    REG_CREEP_SPEED:  creep_reg <= cfg_data[CREEP_W-1:0];
                    REG_FINISH_TOL:   tol_reg   <= cfg_data[TOL_W-1:0];
                    default:          tick_reg  <= tick_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        dv_reg  <= dv_next;
        rem_reg <= rem_next;
        sq_reg  <= sq_next;
        if (accept)
        begin
            cmd_reg    <= cmd_t'(command);
            dist_reg   <= move_distance;
            top_reg    <= top_speed;
            fin_reg    <= final_speed;
            acc_in_reg <= accel_rate;
        end
        if (emit)
        begin
            res_phase_reg    <= phase_reg;
            res_speed_reg    <= speed_reg;
            res_position_reg <= position_reg;
            res_done_reg     <= (phase_reg == PH_DONE);
        end
    end

    assign status.not_tick   = (cmd_reg != CMD_TICK);
    assign status.idle_phase = (phase_reg == PH_IDLE) || (phase_reg == PH_DONE);
    assign status.not_accel  = (phase_reg != PH_ACCEL);

    assign phase        = res_phase_reg;
    assign speed_now    = res_speed_reg;
    assign position_now = res_position_reg;
    assign done_res     = res_done_reg;

endmodule

// ===== rtl/tmprof_sequencer.sv =====
// Microcode table, step counter, jump logic and the item and result handshakes.
module tmprof_sequencer (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_ready,
    output logic                 result_valid,
    input  logic                 result_ready,
    input  tmprof_pkg::status_t  status,
    output tmprof_pkg::ctrl_t    ctrl,
    output logic                 accept,
    output logic                 emit
);
    import tmprof_pkg::*;

    localparam int PC_W = 5;

    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_NOT_TICK,
        COND_IDLE_PHASE,
        COND_NOT_ACCEL
    } cond_t;

    typedef struct packed {
        ctrl_t            ctrl;
        cond_t            cond;
        logic [PC_W-1:0]  target;
        logic             last;
    } uword_t;

    typedef enum logic {
        SEQ_IDLE,
        SEQ_RUN
    } seq_state_t;

    localparam logic [PC_W-1:0] ST_DISPATCH = 5'd0;
    localparam logic [PC_W-1:0] ST_SPEED    = 5'd18;
    localparam logic [PC_W-1:0] ST_OTHER    = 5'd24;
    localparam logic [PC_W-1:0] ST_EMIT     = 5'd25;

    function automatic uword_t mk(input op_t op, input logic me, input logic mc,
                                  input asrc_t a, input bsrc_t b, input part_t p,
                                  input cond_t c, input logic [PC_W-1:0] t,
                                  input logic last);
        mk = '{ctrl: '{op: op, mul_en: me, mul_clr: mc, a_src: a, b_src: b, part: p},
               cond: c, target: t, last: last};
    endfunction

    function automatic uword_t rom(input logic [PC_W-1:0] pc);
        case (pc)
            5'd0:  rom = mk(OP_REM, 1'b0, 1'b0, SRC_ACCEL, SRCB_TICK, PART_LL,
                            COND_NOT_TICK, ST_OTHER, 1'b0);
            5'd1:  rom = mk(OP_NOP, 1'b1, 1'b1, SRC_ACCEL, SRCB_TICK, PART_LL,
                            COND_IDLE_PHASE, ST_EMIT, 1'b0);
            5'd2:  rom = mk(OP_NOP, 1'b1, 1'b0, SRC_ACCEL, SRCB_TICK, PART_LH,
                            COND_NEVER, ST_DISPATCH, 1'b0);
            5'd3:  rom = mk(OP_NOP, 1'b1, 1'b0, SRC_ACCEL, SRCB_TICK, PART_HL,
                            COND_NEVER, ST_DISPATCH, 1'b0);
            5'd4:  rom = mk(OP_NOP, 1'b1, 1'b0, SRC_ACCEL, SRCB_TICK, PART_HH,
                            COND_NEVER, ST_DISPATCH, 1'b0);
            5'd5:  rom = mk(OP_SAVE_DV, 1'b1, 1'b1, SRC_SPEED, SRCB_SPEED, PART_LL,
                            COND_NOT_ACCEL, ST_SPEED, 1'b0);
            5'd6:  rom = mk(OP_NOP, 1'b1, 1'b0, SRC_SPEED, SRCB_SPEED, PART_LH,
                            COND_NEVER, ST_DISPATCH, 1'b0);
            5'd7:  rom = mk(OP_NOP, 1'b1, 1'b0, SRC_SPEED, SRCB_SPEED, PART_HL,
                            COND_NEVER, ST_DISPATCH, 1'b0);
            5'd8:  rom = mk(OP_NOP, 1'b1, 1'b0, SRC_SPEED, SRCB_SPEED, PART_HH,
                            COND_NEVER, ST_DISPATCH, 1'b0);
            5'd9:  rom = mk(OP_SAVE_SQ, 1'b1, 1'b1, SRC_END, SRCB_END, PART_LL,
                            COND_NEVER, ST_DISPATCH, 1'b0);
            5'd10: rom = mk(OP_NOP, 1'b1, 1'b0, SRC_END, SRCB_END, PART_LH,
                            COND_NEVER, ST_DISPATCH, 1'b0);
            5'd11: rom = mk(OP_NOP, 1'b1, 1'b0, SRC_END, SRCB_END, PART_HL,
                            COND_NEVER, ST_DISPATCH, 1'b0);
            5'd12: rom = mk(OP_NOP, 1'b1, 1'b0, SRC_END, SRCB_END, PART_HH,
                            COND_NEVER, ST_DISPATCH, 1'b0);
            5'd13: rom = mk(OP_DIFF, 1'b1, 1'b1, SRC_REM, SRCB_AMIN, PART_LL,
                            COND_NEVER, ST_DISPATCH, 1'b0);
            5'd14: rom = mk(OP_NOP, 1'b1, 1'b0, SRC_REM, SRCB_AMIN, PART_LH,
                            COND_NEVER, ST_DISPATCH, 1'b0);
            5'd15: rom = mk(OP_NOP, 1'b1, 1'b0, SRC_REM, SRCB_AMIN, PART_HL,
                            COND_NEVER, ST_DISPATCH, 1'b0);
            5'd16: rom = mk(OP_NOP, 1'b1, 1'b0, SRC_REM, SRCB_AMIN, PART_HH,
                            COND_NEVER, ST_DISPATCH, 1'b0);
            5'd17: rom = mk(OP_BRAKE, 1'b0, 1'b0, SRC_ACCEL, SRCB_TICK, PART_LL,
                            COND_NEVER, ST_DISPATCH, 1'b0);
            5'd18: rom = mk(OP_SPEED, 1'b0, 1'b0, SRC_ACCEL, SRCB_TICK, PART_LL,
                            COND_NEVER, ST_DISPATCH, 1'b0);
            5'd19: rom = mk(OP_NOP, 1'b1, 1'b1, SRC_SPEED, SRCB_TICK, PART_LL,
                            COND_NEVER, ST_DISPATCH, 1'b0);
            5'd20: rom = mk(OP_NOP, 1'b1, 1'b0, SRC_SPEED, SRCB_TICK, PART_LH,
                            COND_NEVER, ST_DISPATCH, 1'b0);
            5'd21: rom = mk(OP_NOP, 1'b1, 1'b0, SRC_SPEED, SRCB_TICK, PART_HL,
                            COND_NEVER, ST_DISPATCH, 1'b0);
            5'd22: rom = mk(OP_NOP, 1'b1, 1'b0, SRC_SPEED, SRCB_TICK, PART_HH,
                            COND_NEVER, ST_DISPATCH, 1'b0);
            5'd23: rom = mk(OP_POS, 1'b0, 1'b0, SRC_ACCEL, SRCB_TICK, PART_LL,
                            COND_ALWAYS, ST_EMIT, 1'b0);
            5'd24: rom = mk(OP_CMD, 1'b0, 1'b0, SRC_ACCEL, SRCB_TICK, PART_LL,
                            COND_NEVER, ST_DISPATCH, 1'b0);
            default: rom = mk(OP_NOP, 1'b0, 1'b0, SRC_ACCEL, SRCB_TICK, PART_LL,
                              COND_NEVER, ST_DISPATCH, 1'b1);
        endcase
    endfunction

    seq_state_t       state_reg, state_next;
    logic [PC_W-1:0]  pc_reg, pc_next;
    logic             result_valid_reg, result_valid_next;
    uword_t           uword;
    logic             jump;
    logic             out_free;

    always_comb
    begin
        uword    = rom(pc_reg);
        out_free = !result_valid_reg || result_ready;
        case (uword.cond)
            COND_ALWAYS:     jump = 1'b1;
            COND_NOT_TICK:   jump = status.not_tick;
            COND_IDLE_PHASE: jump = status.idle_phase;
            COND_NOT_ACCEL:  jump = status.not_accel;
            default:         jump = 1'b0;
        endcase

        state_next = state_reg;
        pc_next    = pc_reg;
        emit       = 1'b0;
        accept     = 1'b0;
        ctrl       = CTRL_NOP;

        case (state_reg)
            SEQ_RUN:
            begin
                ctrl = uword.ctrl;
                if (uword.last)
                begin
                    if (out_free)
                    begin
                        emit       = 1'b1;
                        state_next = SEQ_IDLE;
                    end
                end
                else
                begin
                    pc_next = jump ? uword.target : (pc_reg + PC_W'(1));
                end
            end
            default:
            begin
                if (item_valid)
                begin
                    accept     = 1'b1;
                    state_next = SEQ_RUN;
                    pc_next    = ST_DISPATCH;
                end
            end
        endcase

        result_valid_next = emit ? 1'b1 : (result_ready ? 1'b0 : result_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= SEQ_IDLE;
            pc_reg           <= ST_DISPATCH;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            pc_reg           <= pc_next;
            result_valid_reg <= result_valid_next;
        end
    end

    assign item_ready   = (state_reg == SEQ_IDLE);
    assign result_valid = result_valid_reg;

endmodule

// ===== rtl/trapezoid_motion_profile_top.sv =====
// Top level of the trapezoid motion profile generator.
// A tick while accelerating runs the whole microcode program, a tick while braking skips
// the braking test, and a tick while idle or complete, a start, a clear or a no-op skips the products.
// The next item is taken in the cycle after the result is loaded. The microcode
// program runs every product as four half-width partial products.
// Reset returns the motion state to idle and the configuration registers to defaults.
module trapezoid_motion_profile_top #(
    parameter int DATA_WIDTH = tmprof_pkg::DATA_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    output logic                                item_ready,
    input  logic [1:0]                          command,
    input  logic signed [DATA_WIDTH-1:0]        move_distance,
    input  logic signed [DATA_WIDTH-1:0]        top_speed,
    input  logic signed [DATA_WIDTH-1:0]        final_speed,
    input  logic signed [DATA_WIDTH-1:0]        accel_rate,
    output logic                                result_valid,
    input  logic                                result_ready,
    output logic [1:0]                          phase,
    output logic signed [DATA_WIDTH-1:0]        speed_now,
    output logic signed [DATA_WIDTH-1:0]        position_now,
    output logic                                done_res,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [tmprof_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [tmprof_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import tmprof_pkg::*;

    ctrl_t   ctrl;
    status_t status;
    logic    accept;
    logic    emit;

    assign cfg_ready = 1'b1;

    tmprof_sequencer u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .status       (status),
        .ctrl         (ctrl),
        .accept       (accept),
        .emit         (emit)
    );

    tmprof_datapath #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (ctrl),
        .accept        (accept),
        .emit          (emit),
        .command       (command),
        .move_distance (move_distance),
        .top_speed     (top_speed),
        .final_speed   (final_speed),
        .accel_rate    (accel_rate),
        .cfg_write     (cfg_valid && cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .status        (status),
        .phase         (phase),
        .speed_now     (speed_now),
        .position_now  (position_now),
        .done_res      (done_res)
    );

endmodule
